/* rtl/clipped_line_raster_1bpp_macros.svh */
// ----------------------------------------------------------------------------
// clipped line raster assertion macros
// shared concurrent check forms for the raster checker
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_RASTER_1BPP_MACROS_SVH
`define CLIPPED_LINE_RASTER_1BPP_MACROS_SVH

// same-cycle implication
`define CLR1_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clr1 check failed");

// next-cycle implication
`define CLR1_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clr1 check failed");

`endif

/* rtl/clr1_pkg.sv */
// ----------------------------------------------------------------------------
// clr1_pkg
// types and constants shared by the line raster front, queue and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clr1_pkg;

    localparam int STORE_DEPTH   = 4096;
    localparam int ADDR_W        = 12;
    localparam int COORD_W       = 13;
    localparam int DELTA_W       = 12;
    localparam int ERR_W         = 15;
    localparam int ROW_W         = 10;
    localparam int LIN_W         = 20;
    localparam int PIX_PER_BYTE  = 8;
    localparam logic [7:0] MSB_PIXEL = 8'h80;
    localparam int ROW_BYTES_DEF = 32;
    localparam int ROWS_DEF      = 128;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        ACT_LINE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        action_t              action;
        logic [1:0]           mode;
        logic                 skip;
        coord_t               x0;
        coord_t               y0;
        coord_t               x1;
        coord_t               y1;
        logic [DELTA_W-1:0]   adx;
        logic [DELTA_W-1:0]   ady;
        logic                 sx_neg;
        logic                 sy_neg;
        logic [ADDR_W-1:0]    addr;
        logic [7:0]           wdata;
    } cmd_t;

endpackage

/* rtl/clr1_front.sv */
// ----------------------------------------------------------------------------
// clr1_front
// takes input beats, sorts lines from spans and prepares stepping terms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clr1_front #(
    parameter int ROW_BYTES = clr1_pkg::ROW_BYTES_DEF,
    parameter int ROWS      = clr1_pkg::ROWS_DEF
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic signed [11:0]    s_start_x,
    input  logic signed [11:0]    s_start_y,
    input  logic signed [11:0]    s_end_x,
    input  logic signed [11:0]    s_end_y,
    input  logic [1:0]            s_draw_mode,
    input  logic [11:0]           s_byte_addr,
    input  logic [7:0]            s_write_data,
    input  logic                  q_full,
    output logic                  q_push,
    output clr1_pkg::cmd_t        q_cmd
);

    localparam clr1_pkg::coord_t XMAX    = clr1_pkg::coord_t'(ROW_BYTES * 8 - 1);
    localparam clr1_pkg::coord_t PLANE_H = clr1_pkg::coord_t'(ROWS);

    clr1_pkg::coord_t x0, y0, x1, y1, dx, dy, adx_w, ady_w;
    clr1_pkg::coord_t lo_raw, hi_raw, lo, hi, span_w;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        x0 = {s_start_x[11], s_start_x};
        y0 = {s_start_y[11], s_start_y};
        x1 = {s_end_x[11], s_end_x};
        y1 = {s_end_y[11], s_end_y};
        dx = x1 - x0;
        dy = y1 - y0;
        adx_w = dx[clr1_pkg::COORD_W-1] ? -dx : dx;
        ady_w = dy[clr1_pkg::COORD_W-1] ? -dy : dy;

        // horizontal span: order, clamp, skip when off the plane
        lo_raw = (x0 < x1) ? x0 : x1;
        hi_raw = (x0 < x1) ? x1 : x0;
        lo     = (lo_raw < 0) ? '0 : lo_raw;
        hi     = (hi_raw > XMAX) ? XMAX : hi_raw;
        span_w = hi - lo;

        q_cmd.action = clr1_pkg::action_t'(s_action);
        q_cmd.mode   = s_draw_mode;
        q_cmd.addr   = s_byte_addr;
        q_cmd.wdata  = s_write_data;

        if (dy == '0) begin
            q_cmd.skip   = (y0 < 0) || (y0 >= PLANE_H) || (lo > hi);
            q_cmd.x0     = lo;
            q_cmd.x1     = hi;
            q_cmd.y0     = y0;
            q_cmd.y1     = y0;
            q_cmd.adx    = span_w[clr1_pkg::DELTA_W-1:0];
            q_cmd.ady    = '0;
            q_cmd.sx_neg = 1'b0;
            q_cmd.sy_neg = 1'b0;
        end else begin
            q_cmd.skip   = 1'b0;
            q_cmd.x0     = x0;
            q_cmd.x1     = x1;
            q_cmd.y0     = y0;
            q_cmd.y1     = y1;
            q_cmd.adx    = adx_w[clr1_pkg::DELTA_W-1:0];
            q_cmd.ady    = ady_w[clr1_pkg::DELTA_W-1:0];
            q_cmd.sx_neg = dx[clr1_pkg::COORD_W-1];
            q_cmd.sy_neg = dy[clr1_pkg::COORD_W-1];
        end
    end

endmodule

/* rtl/clr1_queue.sv */
// ----------------------------------------------------------------------------
// clr1_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clr1_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  clr1_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output clr1_pkg::cmd_t    pop_cmd
);

    localparam int PTR_W = $clog2(clr1_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(clr1_pkg::QUEUE_DEPTH + 1);

    clr1_pkg::cmd_t     entry_reg [clr1_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(clr1_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(clr1_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(clr1_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/clr1_back.sv */
// ----------------------------------------------------------------------------
// clr1_back
// bresenham stepper, byte read and write, frame store read-modify-write and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clr1_back #(
    parameter int ROW_BYTES = clr1_pkg::ROW_BYTES_DEF,
    parameter int ROWS      = clr1_pkg::ROWS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  clr1_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_read_data,
    output logic [1:0]        m_done_action
);

    localparam clr1_pkg::coord_t PLANE_W = clr1_pkg::coord_t'(ROW_BYTES * 8);
    localparam clr1_pkg::coord_t PLANE_H = clr1_pkg::coord_t'(ROWS);
    localparam int AW = clr1_pkg::ADDR_W;
    localparam int EW = clr1_pkg::ERR_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PIX  = 4'b0010,
        ST_RMW  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [7:0]             frame_store_reg [clr1_pkg::STORE_DEPTH];
    logic [7:0]             rd_data_reg;

    clr1_pkg::coord_t       x_reg, y_reg, x1_reg, y1_reg;
    clr1_pkg::coord_t       x_next, y_next;
    logic signed [EW-1:0]   err_reg, err_next;
    logic [clr1_pkg::DELTA_W-1:0] adx_reg, ady_reg;
    logic                   sx_neg_reg, sy_neg_reg;
    clr1_pkg::action_t      action_reg;
    logic [1:0]             mode_reg;
    logic [AW-1:0]          pix_addr_reg, pix_addr_next;
    logic [7:0]             pix_mask_reg, pix_mask_next;
    logic                   last_reg, last_next;

    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;
    logic [1:0]             out_action_reg;
    logic                   out_load;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [7:0]             mem_wdata;

    logic                   on_plane, at_end, step_x, step_y, load_cmd;
    logic signed [EW:0]     e2, adx_s, ady_s;
    logic [clr1_pkg::LIN_W-1:0] lin_addr;

    assign m_valid       = out_valid_reg;
    assign m_read_data   = out_data_reg;
    assign m_done_action = out_action_reg;

    always_comb begin
        on_plane = (x_reg >= 0) && (x_reg < PLANE_W) && (y_reg >= 0) && (y_reg < PLANE_H);
        at_end   = (x_reg == x1_reg) && (y_reg == y1_reg);
        e2       = {err_reg, 1'b0};
        adx_s    = $signed({{(EW + 1 - clr1_pkg::DELTA_W){1'b0}}, adx_reg});
        ady_s    = $signed({{(EW + 1 - clr1_pkg::DELTA_W){1'b0}}, ady_reg});
        step_x   = e2 > -ady_s;
        step_y   = e2 < adx_s;
        lin_addr = clr1_pkg::LIN_W'(y_reg[clr1_pkg::ROW_W-1:0]) *
                   clr1_pkg::LIN_W'(ROW_BYTES) +
                   clr1_pkg::LIN_W'(x_reg[clr1_pkg::COORD_W-2:3]);
        out_load = !out_valid_reg || m_ready;
    end

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        err_next      = err_reg;
        pix_addr_next = pix_addr_reg;
        pix_mask_next = pix_mask_reg;
        last_next     = last_reg;
        q_pop         = 1'b0;
        load_cmd      = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = pix_addr_reg;
        mem_raddr     = lin_addr[AW-1:0];
        mem_wdata     = rd_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    load_cmd = 1'b1;
                    x_next   = q_cmd.x0;
                    y_next   = q_cmd.y0;
                    err_next = EW'($signed({1'b0, q_cmd.adx})) -
                               EW'($signed({1'b0, q_cmd.ady}));
                    unique case (q_cmd.action)
                        clr1_pkg::ACT_LINE: begin
                            state_next = q_cmd.skip ? ST_DONE : ST_PIX;
                        end
                        clr1_pkg::ACT_WRITE: begin
                            mem_we     = 1'b1;
                            mem_waddr  = q_cmd.addr;
                            mem_wdata  = q_cmd.wdata;
                            state_next = ST_DONE;
                        end
                        clr1_pkg::ACT_READ: begin
                            mem_re     = 1'b1;
                            mem_raddr  = q_cmd.addr;
                            state_next = ST_DONE;
                        end
                        clr1_pkg::ACT_NONE: begin
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PIX: begin
                if (!at_end) begin
                    if (step_x) begin
                        x_next = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                    end
                    if (step_y) begin
                        y_next = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                    end
                    err_next = err_reg - (step_x ? EW'(ady_reg) : '0)
                                       + (step_y ? EW'(adx_reg) : '0);
                end
                if (on_plane) begin
                    mem_re        = 1'b1;
                    pix_addr_next = lin_addr[AW-1:0];
                    pix_mask_next = clr1_pkg::MSB_PIXEL >> x_reg[2:0];
                    last_next     = at_end;
                    state_next    = ST_RMW;
                end else if (at_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_RMW: begin
                mem_we = 1'b1;
                priority if (mode_reg == clr1_pkg::MODE_CLEAR) begin
                    mem_wdata = rd_data_reg & ~pix_mask_reg;
                end else if (mode_reg == clr1_pkg::MODE_TOGGLE) begin
                    mem_wdata = rd_data_reg ^ pix_mask_reg;
                end else begin
                    mem_wdata = rd_data_reg | pix_mask_reg;
                end
                state_next = last_reg ? ST_DONE : ST_PIX;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        err_reg      <= err_next;
        pix_addr_reg <= pix_addr_next;
        pix_mask_reg <= pix_mask_next;
        last_reg     <= last_next;
        if (load_cmd) begin
            x1_reg     <= q_cmd.x1;
            y1_reg     <= q_cmd.y1;
            adx_reg    <= q_cmd.adx;
            ady_reg    <= q_cmd.ady;
            sx_neg_reg <= q_cmd.sx_neg;
            sy_neg_reg <= q_cmd.sy_neg;
            action_reg <= q_cmd.action;
            mode_reg   <= q_cmd.mode;
        end
        if (state_reg == ST_DONE && out_load) begin
            out_data_reg   <= (action_reg == clr1_pkg::ACT_READ) ? rd_data_reg : '0;
            out_action_reg <= 2'(action_reg);
        end
    end

    // frame store, single write and single registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_store_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= frame_store_reg[mem_raddr];
        end
    end

endmodule

/* rtl/clipped_line_raster_1bpp.sv */
// line: each pixel on the plane takes a read in ST_PIX and a read-modify-write in ST_RMW;
//   pixels stepped off the plane pass through ST_PIX only
// byte write, byte read and no-op: from accept through the queue, ST_IDLE, ST_DONE and the result register
// steady state: the back takes one beat at a time and finishes it before it pops the next
// input queue holds two beats, so intake runs ahead of the stepper
// reset clears queue, sequencer and result valid; store contents undefined
// ----------------------------------------------------------------------------
// clipped_line_raster_1bpp
// 1 bpp frame store with clipped line drawing and byte access
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clipped_line_raster_1bpp #(
    parameter int ROW_BYTES = clr1_pkg::ROW_BYTES_DEF,
    parameter int ROWS      = clr1_pkg::ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic signed [11:0]    s_start_x,
    input  logic signed [11:0]    s_start_y,
    input  logic signed [11:0]    s_end_x,
    input  logic signed [11:0]    s_end_y,
    input  logic [1:0]            s_draw_mode,
    input  logic [11:0]           s_byte_addr,
    input  logic [7:0]            s_write_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_read_data,
    output logic [1:0]            m_done_action
);

    logic              q_full, q_empty, q_push, q_pop;
    clr1_pkg::cmd_t    push_cmd, pop_cmd;

    clr1_front #(
        .ROW_BYTES (ROW_BYTES),
        .ROWS      (ROWS)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_draw_mode  (s_draw_mode),
        .s_byte_addr  (s_byte_addr),
        .s_write_data (s_write_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    clr1_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .pop_cmd  (pop_cmd)
    );

    clr1_back #(
        .ROW_BYTES (ROW_BYTES),
        .ROWS      (ROWS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_done_action (m_done_action)
    );

endmodule

/* rtl/clr1_checker.sv */
// ----------------------------------------------------------------------------
// clr1_checker
// port-level checks on the raster result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "clipped_line_raster_1bpp_macros.svh"

module clr1_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          m_valid,
    input  logic          m_ready,
    input  logic [7:0]    m_read_data,
    input  logic [1:0]    m_done_action
);

    `CLR1_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_done_action))
    `CLR1_ASSERT_IMP(a_data_zero, aclk, aresetn, m_valid && (m_done_action != clr1_pkg::ACT_READ), m_read_data == 8'h00)
    `CLR1_ASSERT_IMP(a_quiet_after_reset, aclk, aresetn, !$past(aresetn), !m_valid)

endmodule

bind clipped_line_raster_1bpp clr1_checker u_clr1_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_data   (m_read_data),
    .m_done_action (m_done_action)
);
